FILE: rtl/core/anp_pkg.sv
// anp_pkg: shared types and constants for the ASCII number parser.
// Used by anp_decode, anp_accum, ascii_number_parser and anp_checker.
`timescale 1ns / 1ps

package anp_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 8;

  localparam logic [CHAR_W-1:0] CH_NUL  = 8'h00;
  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;  // '9'
  localparam logic [CHAR_W-1:0] CH_A    = 8'h41;  // 'A'
  localparam logic [CHAR_W-1:0] CH_F    = 8'h46;  // 'F'
  localparam logic [CHAR_W-1:0] CH_X    = 8'h58;  // 'X'

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;
  localparam logic [COUNT_W-1:0] COUNT_ONE = 8'd1;
  localparam logic [COUNT_W-1:0] COUNT_HEX_MIN = 8'd3;  // "0X" plus one digit

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_BAD_CHAR      = 3'd1,
    ST_HEX_NO_DIGITS = 3'd2,
    ST_BAD_PREFIX    = 3'd3,
    ST_EMPTY         = 3'd4
  } status_t;

  // Character class of one input byte.
  typedef struct packed {
    logic       term;    // zero byte, ends the token
    logic       digit;   // '0'..'9'
    logic       letter;  // 'A'..'F'
    logic       xmark;   // 'X' (only valid as the second character)
    logic [3:0] val;     // digit weight for '0'..'9' and 'A'..'F'
  } char_class_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    status_t            status;
  } result_t;

endpackage

FILE: rtl/core/ascii_number_parser.sv
// ascii_number_parser: top level; input register, token state, result register.
// Depends on anp_pkg, anp_decode, anp_accum.
`timescale 1ns / 1ps

// Channel  | dir | tdata                | tuser       | transfer
// ---------+-----+----------------------+-------------+--------------------------
// s_axis   | in  | [7:0] ch             | -           | one character per transfer
// m_axis   | out | [31:0] value         | [2:0] status| one result per zero byte
//
// Order: a character is registered on accept and updates the token state as
// it leaves the input register; a zero byte moves its result into the output
// register at that same edge, so m_tvalid rises after the input register and
// the output register. Throughput: one character per cycle while no terminator
// waits on a full output register; the multiply-by-ten add is combinational.
// Reset (rst, synchronous) clears both valid flags and all token state.
// Stalls: only a terminator waits on a full output register; other characters
// keep flowing while a result is held.

module ascii_number_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] value
  output logic [2:0]  m_tuser    // [2:0] status
);

  // input register
  logic                       in_valid;
  logic [anp_pkg::CHAR_W-1:0] ch_q;

  anp_pkg::char_class_t cls;
  anp_pkg::result_t     res;

  logic out_free;
  logic advance;
  logic load_out;

  anp_decode u_decode (
    .ch  (ch_q),
    .cls (cls)
  );

  assign out_free = !m_tvalid || m_tready;
  // a terminator needs room in the result register; anything else moves on
  assign advance  = in_valid && (!cls.term || out_free);
  assign load_out = in_valid && cls.term && out_free;
  assign s_tready = !in_valid || advance;

  anp_accum u_accum (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .cls  (cls),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      ch_q <= s_tdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= res.value;
      m_tuser <= res.status;
    end
  end

endmodule

FILE: rtl/core/anp_decode.sv
// anp_decode: classifies one ASCII byte and extracts its digit weight.
// Depends on anp_pkg.
`timescale 1ns / 1ps

module anp_decode (
  input  logic [anp_pkg::CHAR_W-1:0] ch,
  output anp_pkg::char_class_t       cls
);

  logic [anp_pkg::CHAR_W-1:0] num_off;
  logic [anp_pkg::CHAR_W-1:0] let_off;

  assign num_off = ch - anp_pkg::CH_ZERO;
  assign let_off = ch - anp_pkg::CH_A;

  always_comb begin
    cls.term   = (ch == anp_pkg::CH_NUL);
    cls.digit  = (ch >= anp_pkg::CH_ZERO) && (ch <= anp_pkg::CH_NINE);
    cls.letter = (ch >= anp_pkg::CH_A) && (ch <= anp_pkg::CH_F);
    cls.xmark  = (ch == anp_pkg::CH_X);
    if (cls.letter) begin
      cls.val = let_off[3:0] + 4'd10;
    end else begin
      cls.val = num_off[3:0];
    end
  end

endmodule

FILE: rtl/core/anp_accum.sv
// anp_accum: token state (decimal/hex accumulators, count, flags) and the
// end-of-token result. Depends on anp_pkg.
`timescale 1ns / 1ps

module anp_accum (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,  // a character leaves the input register
  input  anp_pkg::char_class_t cls,
  output anp_pkg::result_t     res    // meaningful when cls.term
);

  logic [anp_pkg::VALUE_W-1:0] dec_acc;
  logic [anp_pkg::VALUE_W-1:0] hex_acc;
  logic [anp_pkg::COUNT_W-1:0] char_count;
  logic                        saw_letter;
  logic                        bad_char;
  logic                        first_is_zero;
  logic                        second_is_x;

  logic [anp_pkg::VALUE_W-1:0] dec_acc_next;
  logic [anp_pkg::VALUE_W-1:0] hex_acc_next;
  logic                        is_hexdig;
  logic                        x_ok;

  assign is_hexdig    = cls.digit || cls.letter;
  assign x_ok         = cls.xmark && (char_count == anp_pkg::COUNT_ONE);
  // acc*10 + d as two shifts and adds; acc*16 + d as a shift
  assign dec_acc_next = (dec_acc << 3) + (dec_acc << 1)
                        + {{(anp_pkg::VALUE_W-4){1'b0}}, cls.val};
  assign hex_acc_next = {hex_acc[anp_pkg::VALUE_W-5:0], cls.val};

  always_comb begin
    res.value  = '0;
    res.status = anp_pkg::ST_OK;
    if (bad_char) begin
      res.status = anp_pkg::ST_BAD_CHAR;
    end else if (saw_letter) begin
      if (char_count < anp_pkg::COUNT_HEX_MIN) begin
        res.status = anp_pkg::ST_HEX_NO_DIGITS;
      end else if (first_is_zero && second_is_x) begin
        res.value = hex_acc;
      end else begin
        res.status = anp_pkg::ST_BAD_PREFIX;
      end
    end else if (char_count == '0) begin
      res.status = anp_pkg::ST_EMPTY;
    end else begin
      res.value = dec_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && cls.term)) begin
      dec_acc       <= '0;
      hex_acc       <= '0;
      char_count    <= '0;
      saw_letter    <= 1'b0;
      bad_char      <= 1'b0;
      first_is_zero <= 1'b0;
      second_is_x   <= 1'b0;
    end else if (step) begin
      if (is_hexdig) begin
        dec_acc <= dec_acc_next;
        hex_acc <= hex_acc_next;
        if (cls.digit && (cls.val == 4'd0) && (char_count == '0)) begin
          first_is_zero <= 1'b1;
        end
        if (cls.letter) begin
          saw_letter <= 1'b1;
        end
      end else if (x_ok) begin
        saw_letter  <= 1'b1;
        second_is_x <= 1'b1;
      end else begin
        bad_char <= 1'b1;
      end
      // invalid characters are not counted
      if ((is_hexdig || x_ok) && (char_count != anp_pkg::COUNT_MAX)) begin
        char_count <= char_count + anp_pkg::COUNT_ONE;
      end
    end
  end

endmodule

FILE: rtl/core/anp_checker.sv
// anp_checker: port-level assertions for ascii_number_parser, bound to it.
// Depends on anp_pkg.
`timescale 1ns / 1ps

module anp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [2:0]  m_tuser
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // error results carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != anp_pkg::ST_OK) |-> m_tdata == '0)
    else $error("nonzero value with error status");

  // status code within range
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == anp_pkg::ST_OK) || (m_tuser == anp_pkg::ST_BAD_CHAR)
      || (m_tuser == anp_pkg::ST_HEX_NO_DIGITS) || (m_tuser == anp_pkg::ST_BAD_PREFIX)
      || (m_tuser == anp_pkg::ST_EMPTY))
    else $error("status out of range");

  // a fresh result follows a terminator transfer
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tdata == anp_pkg::CH_NUL), 2))
    else $error("result without terminator");

  // reset empties the output
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind ascii_number_parser anp_checker u_anp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
